// ===== src/i2cs_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cs_pkg
// Shared types and constants for the I2C bus message sniffer: payload
// structs, bus event format, configuration register map and status groups.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cs_pkg;

  localparam int MSG_DEPTH_DEF = 24;
  localparam int EVQ_DEPTH     = 4;
  localparam int EVQ_AW        = $clog2(EVQ_DEPTH);

  localparam logic [7:0] MARKER_RST      = 8'd77;
  localparam logic [7:0] ROUTE_FIRST_RST = 8'd49;
  localparam logic [7:0] ROUTE_SECOND_RST = 8'd50;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_MARKER       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROUTE_FIRST  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROUTE_SECOND = 2'd2;

  localparam int BITS_PER_BYTE = 8;

  typedef struct packed {
    logic scl;
    logic sda;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_dest;
    logic       out_last;
  } out_item_t;

  typedef enum logic {
    EV_BYTE = 1'b0,
    EV_STOP = 1'b1
  } ev_kind_t;

  typedef struct packed {
    ev_kind_t   kind;
    logic [7:0] data;
  } ev_t;

  typedef struct packed {
    logic [7:0] marker_byte;
    logic [7:0] route_first_char;
    logic [7:0] route_second_char;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } evq_status_t;

  typedef struct packed {
    logic busy;
  } back_status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_EMIT
  } back_state_t;

endpackage

`default_nettype wire

// ===== src/i2cs_front.sv =====
// ----------------------------------------------------------------------------
// i2cs_front
// Line decoder: detects start and stop conditions, assembles bytes from SCL
// rises and pushes data-byte and stop events into the event queue.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cs_front (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_valid,
  output logic                   in_ready,
  input  wire  i2cs_pkg::in_item_t in_data,
  input  wire  i2cs_pkg::evq_status_t q_status,
  output logic                   ev_push,
  output i2cs_pkg::ev_t          ev_data
);
  import i2cs_pkg::*;

  logic       prev_scl_r, prev_scl_nxt;
  logic       prev_sda_r, prev_sda_nxt;
  logic       in_frame_r, in_frame_nxt;
  logic [3:0] bit_count_r, bit_count_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic       addr_done_r, addr_done_nxt;

  logic accept;
  logic scl_chg, sda_chg;

  assign in_ready = !q_status.full;
  assign accept   = in_valid && in_ready;
  assign scl_chg  = in_data.scl != prev_scl_r;
  assign sda_chg  = in_data.sda != prev_sda_r;

  always_comb begin
    prev_scl_nxt  = prev_scl_r;
    prev_sda_nxt  = prev_sda_r;
    in_frame_nxt  = in_frame_r;
    bit_count_nxt = bit_count_r;
    shift_nxt     = shift_r;
    addr_done_nxt = addr_done_r;
    ev_push       = 1'b0;
    ev_data.kind  = EV_BYTE;
    ev_data.data  = shift_r;
    if (accept) begin
      prev_scl_nxt = in_data.scl;
      prev_sda_nxt = in_data.sda;
      if (scl_chg) begin
        if (in_data.scl && in_frame_r) begin
          if (bit_count_r < 4'(BITS_PER_BYTE)) begin
            shift_nxt     = {shift_r[6:0], in_data.sda};
            bit_count_nxt = bit_count_r + 4'd1;
          end else begin
            // ACK slot: byte complete, the address byte is skipped
            ev_push       = addr_done_r;
            bit_count_nxt = 4'd0;
            shift_nxt     = 8'd0;
            addr_done_nxt = 1'b1;
          end
        end
      end else if (sda_chg && in_data.scl) begin
        bit_count_nxt = 4'd0;
        shift_nxt     = 8'd0;
        if (in_data.sda) begin
          in_frame_nxt = 1'b0;
          ev_push      = 1'b1;
          ev_data.kind = EV_STOP;
        end else begin
          in_frame_nxt  = 1'b1;
          addr_done_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_scl_r  <= 1'b1;
      prev_sda_r  <= 1'b1;
      in_frame_r  <= 1'b0;
      bit_count_r <= 4'd0;
      shift_r     <= 8'd0;
      addr_done_r <= 1'b0;
    end else begin
      prev_scl_r  <= prev_scl_nxt;
      prev_sda_r  <= prev_sda_nxt;
      in_frame_r  <= in_frame_nxt;
      bit_count_r <= bit_count_nxt;
      shift_r     <= shift_nxt;
      addr_done_r <= addr_done_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/i2cs_evq.sv =====
// ----------------------------------------------------------------------------
// i2cs_evq
// Short FIFO of bus events between the line decoder and the message engine.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cs_evq (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     push,
  input  wire  i2cs_pkg::ev_t     push_data,
  input  wire                     pop,
  output logic                    head_valid,
  output i2cs_pkg::ev_t           head_data,
  output i2cs_pkg::evq_status_t   status
);
  import i2cs_pkg::*;

  ev_t               slot_r [EVQ_DEPTH];
  logic [EVQ_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [EVQ_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [EVQ_AW:0]   count_r, count_nxt;
  logic              do_push, do_pop;

  assign status.full  = count_r == (EVQ_AW+1)'(EVQ_DEPTH);
  assign status.empty = count_r == '0;
  assign head_valid   = !status.empty;
  assign head_data    = slot_r[rd_ptr_r];
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == EVQ_AW'(EVQ_DEPTH - 1)) ? '0 : wr_ptr_r + EVQ_AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == EVQ_AW'(EVQ_DEPTH - 1)) ? '0 : rd_ptr_r + EVQ_AW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + (EVQ_AW+1)'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - (EVQ_AW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/i2cs_back.sv =====
// ----------------------------------------------------------------------------
// i2cs_back
// Message engine: captures data bytes after the marker into the message
// store, checks the message at stop and walks the store to the output.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cs_back #(
  parameter int MSG_DEPTH = i2cs_pkg::MSG_DEPTH_DEF
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire  i2cs_pkg::cfg_t     cfg,
  input  wire                      ev_valid,
  input  wire  i2cs_pkg::ev_t      ev_data,
  output logic                     ev_pop,
  output logic                     out_valid,
  input  wire                      out_ready,
  output i2cs_pkg::out_item_t      out_data,
  output i2cs_pkg::back_status_t   status
);
  import i2cs_pkg::*;

  localparam int AW = (MSG_DEPTH > 1) ? $clog2(MSG_DEPTH) : 1;
  localparam int LW = $clog2(MSG_DEPTH + 1);

  logic [7:0] msg_mem [MSG_DEPTH];

  back_state_t state_r, state_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic          capturing_r, capturing_nxt;
  logic          bad_r, bad_nxt;
  logic [7:0]    first_r, first_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [LW-1:0] disp_len_r, disp_len_nxt;
  logic          dest_r, dest_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_item_t     out_item_r;

  logic wr_en, rd_en, store_full, hit0, hit1, routed, is_last;

  assign ev_pop     = ev_valid && state_r == BK_IDLE;
  assign store_full = len_r == LW'(MSG_DEPTH);
  assign wr_en      = ev_pop && ev_data.kind == EV_BYTE && capturing_r && !store_full;
  assign hit0       = first_r == cfg.route_first_char;
  assign hit1       = first_r == cfg.route_second_char;
  assign routed     = len_r != '0 && !bad_r && (hit0 || hit1);
  assign rd_en      = state_r == BK_READ;
  assign is_last    = LW'(idx_r) + LW'(1) == disp_len_r;

  assign out_valid   = out_valid_r;
  assign out_data    = out_item_r;
  assign status.busy = state_r != BK_IDLE;

  always_comb begin
    state_nxt     = state_r;
    len_nxt       = len_r;
    capturing_nxt = capturing_r;
    bad_nxt       = bad_r;
    first_nxt     = first_r;
    idx_nxt       = idx_r;
    disp_len_nxt  = disp_len_r;
    dest_nxt      = dest_r;
    out_valid_nxt = out_valid_r;
    case (state_r)
      BK_IDLE: begin
        if (ev_pop) begin
          if (ev_data.kind == EV_BYTE) begin
            if (capturing_r) begin
              if (store_full) begin
                bad_nxt = 1'b1;
              end else begin
                len_nxt = len_r + LW'(1);
                if (len_r == '0) begin
                  first_nxt = ev_data.data;
                end
                if (ev_data.data == 8'd0) begin
                  bad_nxt = 1'b1;
                end
              end
            end
            if (ev_data.data == cfg.marker_byte) begin
              capturing_nxt = 1'b1;
            end
          end else begin
            // stop: hand a routed message to the dispatch walk, clear capture
            if (routed) begin
              state_nxt    = BK_READ;
              idx_nxt      = '0;
              disp_len_nxt = len_r;
              dest_nxt     = !hit0;
            end
            len_nxt       = '0;
            capturing_nxt = 1'b0;
            bad_nxt       = 1'b0;
          end
        end
      end
      BK_READ: begin
        out_valid_nxt = 1'b1;
        state_nxt     = BK_EMIT;
      end
      BK_EMIT: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          if (out_item_r.out_last) begin
            state_nxt = BK_IDLE;
          end else begin
            idx_nxt   = idx_r + AW'(1);
            state_nxt = BK_READ;
          end
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      msg_mem[len_r[AW-1:0]] <= ev_data.data;
    end
    if (rd_en) begin
      out_item_r.out_byte <= msg_mem[idx_r];
      out_item_r.out_dest <= dest_r;
      out_item_r.out_last <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      len_r       <= '0;
      capturing_r <= 1'b0;
      bad_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      capturing_r <= capturing_nxt;
      bad_r       <= bad_nxt;
      out_valid_r <= out_valid_nxt;
    end
    first_r    <= first_nxt;
    idx_r      <= idx_nxt;
    disp_len_r <= disp_len_nxt;
    dest_r     <= dest_nxt;
  end

endmodule

`default_nettype wire

// ===== src/i2c_bus_message_sniffer_top.sv =====
// ----------------------------------------------------------------------------
// i2c_bus_message_sniffer_top
// Passive I2C monitor that collects marked messages and dispatches them by
// their leading routing character.
// ----------------------------------------------------------------------------
// Each accepted item is one sample of the SCL and SDA lines; a sample is taken
// whenever the four-entry event queue between the line decoder and the
// message engine has room. Only completed data bytes and stop conditions
// enter the queue. A stop that dispatches a message keeps the message
// engine busy until its final byte is taken, since each byte is one
// registered read of the message store followed by a hold in the output
// register until it is taken; the decoder keeps sampling meanwhile until
// the queue fills. The message store has no reset: only entries written
// in the current message are ever read.
`default_nettype none

module i2c_bus_message_sniffer_top #(
  parameter int MSG_DEPTH = i2cs_pkg::MSG_DEPTH_DEF
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 in_valid,
  output logic                                in_ready,
  input  wire  i2cs_pkg::in_item_t            in_data,
  output logic                                out_valid,
  input  wire                                 out_ready,
  output i2cs_pkg::out_item_t                 out_data,
  input  wire                                 cfg_we,
  input  wire  [i2cs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire  [7:0]                          cfg_wdata
);
  import i2cs_pkg::*;

  cfg_t         cfg_r, cfg_nxt;
  evq_status_t  q_status;
  back_status_t bk_status;
  logic         ev_push, ev_pop, ev_valid;
  ev_t          ev_in, ev_head;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_MARKER:       cfg_nxt.marker_byte       = cfg_wdata;
        CFG_ROUTE_FIRST:  cfg_nxt.route_first_char  = cfg_wdata;
        CFG_ROUTE_SECOND: cfg_nxt.route_second_char = cfg_wdata;
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.marker_byte       <= MARKER_RST;
      cfg_r.route_first_char  <= ROUTE_FIRST_RST;
      cfg_r.route_second_char <= ROUTE_SECOND_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  i2cs_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_status (q_status),
    .ev_push  (ev_push),
    .ev_data  (ev_in)
  );

  i2cs_evq u_evq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (ev_push),
    .push_data  (ev_in),
    .pop        (ev_pop),
    .head_valid (ev_valid),
    .head_data  (ev_head),
    .status     (q_status)
  );

  i2cs_back #(
    .MSG_DEPTH (MSG_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .ev_valid  (ev_valid),
    .ev_data   (ev_head),
    .ev_pop    (ev_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .status    (bk_status)
  );

  // results appear only during a dispatch walk
  a_out_in_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> bk_status.busy)
    else $error("result shown outside a dispatch");

  // the final byte taken ends the walk
  a_last_ends_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_data.out_last) |=> !bk_status.busy)
    else $error("dispatch continued past the final byte");

  // no events are taken from the queue while a message is being walked
  a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    bk_status.busy |-> !ev_pop)
    else $error("event consumed during dispatch");

  a_queue_sane: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_status.full && q_status.empty))
    else $error("event queue both full and empty");

endmodule

`default_nettype wire

// ===== tb/i2c_sniffer_checker.sv =====
// ----------------------------------------------------------------------------
// i2c_sniffer_checker
// Watches the line-sample and message channels of the I2C bus message sniffer,
// decodes the sampled bus on its own to predict every dispatched byte, and
// compares each accepted result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module i2c_sniffer_checker
  import i2cs_pkg::*;
#(
  parameter int MSG_DEPTH = MSG_DEPTH_DEF
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  input  wire                  in_ready,
  input  in_item_t             in_data,
  input  wire                  out_valid,
  input  wire                  out_ready,
  input  out_item_t            out_data,
  input  wire                  cfg_we,
  input  wire [CFG_IDX_W-1:0]  cfg_index,
  input  wire [7:0]            cfg_wdata,
  output int                   err_count,
  output int                   bytes_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  cfg_t       sniff_cfg;
  logic       last_scl;
  logic       last_sda;
  logic       in_frame;
  logic       addr_seen;
  logic       capture_on;
  logic       msg_bad;
  logic [3:0] bit_cnt;
  logic [7:0] shreg;
  int         msg_len;
  logic [7:0] msg_buf [MSG_DEPTH];
  out_item_t  dispatch_q [$];

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t ns: %s: got %0h, expected %0h", $time, what, got, want);
    err_count++;
  endtask

  task automatic sniff_reset();
    sniff_cfg.marker_byte       = MARKER_RST;
    sniff_cfg.route_first_char  = ROUTE_FIRST_RST;
    sniff_cfg.route_second_char = ROUTE_SECOND_RST;
    last_scl   = 1'b1;
    last_sda   = 1'b1;
    in_frame   = 1'b0;
    addr_seen  = 1'b0;
    capture_on = 1'b0;
    msg_bad    = 1'b0;
    bit_cnt    = '0;
    shreg      = '0;
    msg_len    = 0;
  endtask

  // ACK slot reached: the shifted byte is complete
  task automatic take_byte();
    if (addr_seen) begin
      if (capture_on) begin
        if (msg_len < MSG_DEPTH) begin
          msg_buf[msg_len] = shreg;
          msg_len++;
          if (shreg == 8'h00) msg_bad = 1'b1;
        end else begin
          msg_bad = 1'b1;
        end
      end
      if (shreg == sniff_cfg.marker_byte) capture_on = 1'b1;
    end
    bit_cnt   = '0;
    shreg     = '0;
    addr_seen = 1'b1;
  endtask

  task automatic close_frame();
    out_item_t r;
    logic      dest;
    bit        routed;
    int        i;
    in_frame = 1'b0;
    bit_cnt  = '0;
    shreg    = '0;
    routed   = 1'b0;
    dest     = 1'b0;
    if (msg_len > 0 && !msg_bad) begin
      if (msg_buf[0] == sniff_cfg.route_first_char) begin
        routed = 1'b1;
      end else if (msg_buf[0] == sniff_cfg.route_second_char) begin
        routed = 1'b1;
        dest   = 1'b1;
      end
    end
    if (routed) begin
      for (i = 0; i < msg_len; i++) begin
        r.out_byte = msg_buf[i];
        r.out_dest = dest;
        r.out_last = (i + 1 == msg_len);
        dispatch_q.push_back(r);
      end
    end
    msg_len    = 0;
    capture_on = 1'b0;
    msg_bad    = 1'b0;
  endtask

  task automatic sniff_sample(input in_item_t s);
    logic scl_moved;
    logic sda_moved;
    scl_moved = (s.scl != last_scl);
    sda_moved = (s.sda != last_sda);
    last_scl  = s.scl;
    last_sda  = s.sda;
    if (scl_moved) begin
      if (s.scl && in_frame) begin
        if (bit_cnt < BITS_PER_BYTE) begin
          shreg   = {shreg[6:0], s.sda};
          bit_cnt = bit_cnt + 4'd1;
        end else begin
          take_byte();
        end
      end
    end else if (sda_moved && s.scl) begin
      if (s.sda) begin
        close_frame();
      end else begin
        // start or repeated start: keep the stored message
        in_frame  = 1'b1;
        bit_cnt   = '0;
        shreg     = '0;
        addr_seen = 1'b0;
      end
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      sniff_reset();
      dispatch_q.delete();
      err_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (dispatch_q.size() == 0) begin
          report_mismatch("unexpected dispatched byte", out_data.out_byte, 0);
        end else begin
          want = dispatch_q.pop_front();
          if (out_data.out_byte !== want.out_byte)
            report_mismatch("out_byte", out_data.out_byte, want.out_byte);
          if (out_data.out_dest !== want.out_dest)
            report_mismatch("out_dest", out_data.out_dest, want.out_dest);
          if (out_data.out_last !== want.out_last)
            report_mismatch("out_last", out_data.out_last, want.out_last);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_MARKER:       sniff_cfg.marker_byte       = cfg_wdata;
          CFG_ROUTE_FIRST:  sniff_cfg.route_first_char  = cfg_wdata;
          CFG_ROUTE_SECOND: sniff_cfg.route_second_char = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && in_ready) sniff_sample(in_data);
    end
    bytes_pending <= dispatch_q.size();
  end

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Drives sampled SCL/SDA levels into the I2C bus message sniffer: a few
// directed bus transfers under the reset settings, then randomized transfers,
// broken frames and line noise across several register settings. Line
// samples go out in random bursts and the message side stalls on its own
// pattern; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import i2cs_pkg::*;

  localparam int RAND_ITEMS    = 110;
  localparam int NUM_PHASES    = 6;
  localparam int PHASE_TXNS    = 30;
  localparam int SETTLE        = 64;
  localparam int CYCLE_LIMIT   = 1_000_000;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_PERIODIC
  } rx_mode_t;

  logic                 clk;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_item_t             in_data   = '{scl: 1'b1, sda: 1'b1};
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_data;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_MARKER;
  logic [7:0]           cfg_wdata = 8'h00;

  int          err_count;
  int          bytes_pending;
  int unsigned cycle_cnt = 0;

  // stimulus-side view of the bus and of the register settings
  logic       cur_scl     = 1'b1;
  logic       cur_sda     = 1'b1;
  logic [7:0] marker_val  = MARKER_RST;
  logic [7:0] route_a     = ROUTE_FIRST_RST;
  logic [7:0] route_b     = ROUTE_SECOND_RST;
  logic [7:0] msg_body [$];
  bit         in_valid_up = 1'b0;
  int         burst_left  = 0;
  int         samples_sent = 0;

  rx_mode_t rx_mode  = RX_OPEN;
  int       rx_left  = 0;

  i2c_bus_message_sniffer_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  i2c_sniffer_checker chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data        (out_data),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .err_count       (err_count),
    .bytes_pending   (bytes_pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // message-side stalls: pick a new random pattern whenever the current one runs out
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
      rx_left <= $urandom_range(20, 120);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_OPEN:   out_ready <= 1'b1;
      RX_COIN:   out_ready <= ($urandom_range(0, 1) == 0);
      RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
      default:   out_ready <= ((cycle_cnt % 5) < 2);
    endcase
  end

  function automatic int pick_burst();
    if ($urandom_range(0, 7) == 0) return $urandom_range(40, 80);
    return $urandom_range(1, 12);
  endfunction

  function automatic int pick_gap();
    if ($urandom_range(0, 7) == 0) return $urandom_range(12, 40);
    return $urandom_range(1, 5);
  endfunction

  function automatic logic [7:0] rand_payload();
    return 8'($urandom_range(1, 255));
  endfunction

  task automatic put_sample(input logic scl, input logic sda);
    in_item_t s;
    s.scl = scl;
    s.sda = sda;
    if (!in_valid_up) begin
      repeat (pick_gap()) @(posedge clk);
      burst_left = pick_burst();
    end
    in_valid    <= 1'b1;
    in_data     <= s;
    in_valid_up = 1'b1;
    do @(posedge clk); while (!in_ready);
    cur_scl = scl;
    cur_sda = sda;
    samples_sent++;
    burst_left--;
    if (burst_left == 0) begin
      in_valid    <= 1'b0;
      in_valid_up = 1'b0;
    end
  endtask

  task automatic hold_sender();
    if (in_valid_up) begin
      in_valid    <= 1'b0;
      in_valid_up = 1'b0;
    end
  endtask

  task automatic wait_idle();
    hold_sender();
    do @(posedge clk); while (bytes_pending != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_config(input logic [7:0] m, input logic [7:0] a, input logic [7:0] b);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MARKER;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_index <= CFG_ROUTE_FIRST;
    cfg_wdata <= a;
    @(posedge clk);
    cfg_index <= CFG_ROUTE_SECOND;
    cfg_wdata <= b;
    @(posedge clk);
    cfg_we     <= 1'b0;
    marker_val = m;
    route_a    = a;
    route_b    = b;
  endtask

  // start, or repeated start when SDA is already low with SCL high
  task automatic bus_start();
    if (cur_scl && !cur_sda) put_sample(1'b0, 1'b0);
    if (!cur_sda) put_sample(1'b0, 1'b1);
    if (!cur_scl) put_sample(1'b1, 1'b1);
    put_sample(1'b1, 1'b0);
  endtask

  task automatic bus_bit(input logic b);
    int style;
    style = $urandom_range(0, 3);
    if (cur_scl) begin
      // drop SCL and move SDA together now and then
      if (style == 0) put_sample(1'b0, b);
      else put_sample(1'b0, cur_sda);
    end
    // let SDA change on the SCL rise itself now and then
    if (cur_sda != b && style != 1) put_sample(1'b0, b);
    put_sample(1'b1, b);
  endtask

  task automatic bus_byte(input logic [7:0] v);
    int k;
    for (k = 7; k >= 0; k--) bus_bit(v[k]);
    bus_bit(1'($urandom_range(0, 1)));
  endtask

  task automatic bus_stop();
    if (cur_scl) put_sample(1'b0, cur_sda);
    if (cur_sda) put_sample(1'b0, 1'b0);
    put_sample(1'b1, 1'b0);
    put_sample(1'b1, 1'b1);
  endtask

  task automatic send_message(input bit with_marker, input int restart_at);
    int i;
    bus_start();
    bus_byte(8'($urandom_range(0, 255)));
    if (with_marker) bus_byte(marker_val);
    for (i = 0; i < msg_body.size(); i++) begin
      if (i == restart_at) begin
        bus_start();
        bus_byte(8'($urandom_range(0, 255)));
      end
      bus_byte(msg_body[i]);
    end
    bus_stop();
  endtask

  task automatic load_body(input logic [7:0] first, input int len);
    int i;
    msg_body.delete();
    msg_body.push_back(first);
    for (i = 1; i < len; i++) msg_body.push_back(rand_payload());
  endtask

  task automatic random_message();
    int len;
    int kind;
    int pick;
    int i;
    kind = $urandom_range(0, 19);
    len  = (kind == 0) ? $urandom_range(MSG_DEPTH_DEF - 1, MSG_DEPTH_DEF + 2)
                       : $urandom_range(1, 6);
    pick = $urandom_range(0, 9);
    msg_body.delete();
    if (pick < 4) msg_body.push_back(route_a);
    else if (pick < 8) msg_body.push_back(route_b);
    else msg_body.push_back(8'($urandom_range(0, 255)));
    for (i = 1; i < len; i++) begin
      pick = $urandom_range(0, 39);
      if (pick == 0) msg_body.push_back(8'h00);
      else if (pick == 1) msg_body.push_back(marker_val);
      else msg_body.push_back(rand_payload());
    end
    send_message(kind != 1, (kind == 2) ? $urandom_range(0, len - 1) : -1);
  endtask

  // cut a frame short in the middle of a byte
  task automatic broken_frame();
    int k;
    bus_start();
    bus_byte(8'($urandom_range(0, 255)));
    if ($urandom_range(0, 1)) bus_byte(marker_val);
    bus_byte(($urandom_range(0, 1)) ? route_a : route_b);
    for (k = $urandom_range(1, 7); k > 0; k--) bus_bit(1'($urandom_range(0, 1)));
    if ($urandom_range(0, 1)) bus_stop();
    else bus_start();
  endtask

  task automatic line_noise();
    int k;
    for (k = $urandom_range(2, 10); k > 0; k--)
      put_sample(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  initial begin
    int txn;
    int pick;
    int sample_goal;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // SCL rises outside a frame, then a stop with nothing stored
    put_sample(1'b0, 1'b1);
    put_sample(1'b1, 1'b1);
    put_sample(1'b0, 1'b0);
    put_sample(1'b1, 1'b0);
    put_sample(1'b1, 1'b1);
    // empty message: address and marker only
    msg_body.delete();
    send_message(1'b1, -1);
    // routed to each destination, one with a repeated start inside
    load_body(route_a, 3);
    send_message(1'b1, -1);
    load_body(route_b, 4);
    send_message(1'b1, 2);
    // no marker: nothing captured
    load_body(route_a, 3);
    send_message(1'b0, -1);
    // zero byte spoils the message
    load_body(route_a, 3);
    msg_body[1] = 8'h00;
    send_message(1'b1, -1);
    // leading byte matches neither route
    load_body(8'h58, 2);
    send_message(1'b1, -1);
    // marker inside a captured message is stored
    load_body(route_a, 3);
    msg_body[1] = marker_val;
    send_message(1'b1, -1);
    // store exactly full, then one byte too many
    load_body(route_b, MSG_DEPTH_DEF);
    send_message(1'b1, -1);
    load_body(route_a, MSG_DEPTH_DEF + 1);
    send_message(1'b1, -1);
    // all-ones and single-byte message
    load_body(route_a, 1);
    send_message(1'b1, -1);
    load_body(route_b, 2);
    msg_body[1] = 8'hFF;
    send_message(1'b1, 0);
    broken_frame();
    bus_stop();

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) begin
        wait_idle();
        case (p)
          1: write_config(8'h00, 8'hFF, 8'h01);
          2: write_config(8'hFF, 8'h7E, 8'h7E);
          3: write_config(8'($urandom), 8'($urandom), 8'($urandom));
          4: write_config(8'hA5, 8'h01, 8'hFF);
          default: write_config(8'($urandom), 8'h00, 8'($urandom_range(1, 255)));
        endcase
      end
      sample_goal = samples_sent + RAND_ITEMS / NUM_PHASES;
      txn = 0;
      while (txn < PHASE_TXNS && samples_sent < sample_goal) begin
        pick = $urandom_range(0, 9);
        if (pick < 7) random_message();
        else if (pick < 9) broken_frame();
        else line_noise();
        txn++;
      end
      bus_stop();
    end

    wait_idle();
    if (err_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
